// File: rtl/tlsd_pkg.sv
// Shared types and constants for the TLS record deframer.
// No dependencies; imported by every module of the block.
package tlsd_pkg;

    localparam logic [15:0] TLS_VERSION     = 16'h0303;
    localparam logic [2:0]  HDR_LAST_IDX    = 3'd4;
    localparam logic [7:0]  TYPE_CCS        = 8'd20;
    localparam logic [7:0]  TYPE_ALERT      = 8'd21;
    localparam logic [7:0]  TYPE_APPDATA    = 8'd23;
    localparam logic [15:0] MAX_LEN_RST     = 16'd16640;
    localparam logic [63:0] START_SEQ_RST   = 64'd0;

    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [1:0] REG_MAX_LEN   = 2'd0;
    localparam logic [1:0] REG_FILTER    = 2'd1;
    localparam logic [1:0] REG_START_SEQ = 2'd2;

    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_CLOSE = 1'b1;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_VERSION     = 3'd1;
    localparam logic [2:0] ERR_TOO_LARGE   = 3'd2;
    localparam logic [2:0] ERR_CLOSED_HDR  = 3'd3;
    localparam logic [2:0] ERR_CLOSED_PAY  = 3'd4;
    localparam logic [2:0] ERR_ALERT       = 3'd5;
    localparam logic [2:0] ERR_UNEXPECTED  = 3'd6;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'b01,
        PH_PAYLOAD = 2'b10
    } t_phase;

    typedef struct packed {
        logic [15:0] max_len;
        logic        filter;
        logic        seq_load;
        logic [63:0] seq_value;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  record_type;
        logic [15:0] record_length;
        logic [63:0] record_sequence;
        logic        last;
        logic [2:0]  error_code;
    } t_entry;

endpackage

// File: rtl/tlsd_front.sv
// Front end: header collection, record checks, type filtering and sequencing.
// Depends on tlsd_pkg; produces one queue entry per result transaction.
module tlsd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tlsd_pkg::t_cfg       i_cfg,
    input  logic                 i_accept,
    input  logic                 i_action,
    input  logic [7:0]           i_data_byte,
    output logic                 o_push,
    output tlsd_pkg::t_entry     o_entry
);
    import tlsd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_seen, n_seen;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_ver, n_ver;
    logic [15:0] r_len, n_len;
    logic [15:0] r_rem, n_rem;
    logic        r_drop, n_drop;
    logic [63:0] r_next_seq, n_next_seq;
    logic [63:0] r_prev_seq, n_prev_seq;
    logic        r_halted, n_halted;

    always_comb begin
        n_phase    = r_phase;
        n_seen     = r_seen;
        n_type     = r_type;
        n_ver      = r_ver;
        n_len      = r_len;
        n_rem      = r_rem;
        n_drop     = r_drop;
        n_next_seq = r_next_seq;
        n_prev_seq = r_prev_seq;
        n_halted   = r_halted;
        o_push     = 1'b0;
        o_entry.kind            = KIND_PAYLOAD;
        o_entry.payload_byte    = 8'd0;
        o_entry.record_type     = r_type;
        o_entry.record_length   = r_len;
        o_entry.record_sequence = 64'd0;
        o_entry.last            = 1'b0;
        o_entry.error_code      = ERR_NONE;

        if (i_accept && !r_halted) begin
            if (i_action == ACT_CLOSE) begin
                o_push             = 1'b1;
                o_entry.kind       = KIND_ERROR;
                o_entry.error_code = (r_phase == PH_HEADER) ? ERR_CLOSED_HDR : ERR_CLOSED_PAY;
                n_halted           = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        case (r_seen) inside
                            3'd0:        n_type = i_data_byte;
                            [3'd1:3'd2]: n_ver  = {r_ver[7:0], i_data_byte};
                            default:     n_len  = {r_len[7:0], i_data_byte};
                        endcase
                        n_seen = r_seen + 3'd1;
                        if (r_seen == HDR_LAST_IDX) begin
                            n_seen                = 3'd0;
                            n_drop                = 1'b0;
                            o_entry.record_type   = n_type;
                            o_entry.record_length = n_len;
                            if (n_ver != TLS_VERSION) begin
                                o_push             = 1'b1;
                                o_entry.kind       = KIND_ERROR;
                                o_entry.error_code = ERR_VERSION;
                                n_halted           = 1'b1;
                            end else if (n_len > i_cfg.max_len) begin
                                o_push             = 1'b1;
                                o_entry.kind       = KIND_ERROR;
                                o_entry.error_code = ERR_TOO_LARGE;
                                n_halted           = 1'b1;
                            end else if (i_cfg.filter) begin
                                if (n_len == 16'd0) begin
                                    n_phase = PH_HEADER;
                                end else if (n_type == TYPE_CCS) begin
                                    n_drop  = 1'b1;
                                    n_phase = PH_PAYLOAD;
                                    n_rem   = n_len;
                                end else if (n_type == TYPE_ALERT) begin
                                    o_push             = 1'b1;
                                    o_entry.kind       = KIND_ERROR;
                                    o_entry.error_code = ERR_ALERT;
                                    n_halted           = 1'b1;
                                end else if (n_type != TYPE_APPDATA) begin
                                    o_push             = 1'b1;
                                    o_entry.kind       = KIND_ERROR;
                                    o_entry.error_code = ERR_UNEXPECTED;
                                    n_halted           = 1'b1;
                                end else begin
                                    o_push                  = 1'b1;
                                    o_entry.kind            = KIND_START;
                                    o_entry.record_sequence = r_next_seq;
                                    n_prev_seq              = r_next_seq;
                                    n_next_seq              = r_next_seq + 64'd1;
                                    n_phase                 = PH_PAYLOAD;
                                    n_rem                   = n_len;
                                end
                            end else begin
                                o_push       = 1'b1;
                                o_entry.kind = KIND_START;
                                o_entry.last = (n_len == 16'd0);
                                if (n_len != 16'd0) begin
                                    n_phase = PH_PAYLOAD;
                                    n_rem   = n_len;
                                end
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        n_rem = r_rem - 16'd1;
                        if (n_rem == 16'd0) begin
                            n_phase = PH_HEADER;
                            n_drop  = 1'b0;
                        end
                        if (!r_drop) begin
                            o_push                  = 1'b1;
                            o_entry.payload_byte    = i_data_byte;
                            o_entry.record_sequence = i_cfg.filter ? r_prev_seq : 64'd0;
                            o_entry.last            = (n_rem == 16'd0);
                        end
                    end
                    default: n_phase = PH_HEADER;
                endcase
            end
        end

        if (i_cfg.seq_load) begin
            n_next_seq = i_cfg.seq_value;
            n_prev_seq = i_cfg.seq_value - 64'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_seen     <= 3'd0;
            r_type     <= 8'd0;
            r_ver      <= 16'd0;
            r_len      <= 16'd0;
            r_rem      <= 16'd0;
            r_drop     <= 1'b0;
            r_next_seq <= START_SEQ_RST;
            r_prev_seq <= START_SEQ_RST - 64'd1;
            r_halted   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_seen     <= n_seen;
            r_type     <= n_type;
            r_ver      <= n_ver;
            r_len      <= n_len;
            r_rem      <= n_rem;
            r_drop     <= n_drop;
            r_next_seq <= n_next_seq;
            r_prev_seq <= n_prev_seq;
            r_halted   <= n_halted;
        end
    end

`ifndef SYNTHESIS
    a_no_push_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !o_push)
        else $error("result produced while halted");
    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_seen == 3'd0 && r_rem != 16'd0))
        else $error("payload phase with stale header count or zero remaining");
`endif

endmodule

// File: rtl/tlsd_fifo.sv
// Short result queue between the front end and the output stage.
// Depends on tlsd_pkg for the entry type.
module tlsd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tlsd_pkg::t_entry i_wr_data,
    input  logic             i_pop,
    output tlsd_pkg::t_entry o_rd_data,
    output logic             o_full,
    output logic             o_empty
);
    import tlsd_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue overflow");
`endif

endmodule

// File: rtl/tlsd_back.sv
// Output stage: drains the result queue into the registered output channel.
// Depends on tlsd_pkg for the entry type.
module tlsd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  tlsd_pkg::t_entry i_rd_data,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output tlsd_pkg::t_entry o_entry
);
    import tlsd_pkg::*;

    logic   r_valid;
    t_entry r_entry;

    assign o_pop = !i_empty && (!r_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_rd_data;
        end
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;

`ifndef SYNTHESIS
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_entry)))
        else $error("stalled output transaction lost");
`endif

endmodule

// File: rtl/tls_record_deframer_core.sv
// TLS 1.3 record deframer.
// Throughput one byte per cycle while the queue is not full.
// Results pass through a FIFO_DEPTH-entry queue and a registered output stage.
// Input stalls only while the queue is full.
// Synchronous active-low reset: header phase, config to defaults, errors cleared.
// Depends on tlsd_pkg, tlsd_front, tlsd_fifo, tlsd_back.
module tls_record_deframer_core #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_action,
    input  logic [7:0]                         i_data_byte,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_kind,
    output logic [7:0]                         o_payload_byte,
    output logic [7:0]                         o_record_type,
    output logic [15:0]                        o_record_length,
    output logic [63:0]                        o_record_sequence,
    output logic                               o_last,
    output logic [2:0]                         o_error_code,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tlsd_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [tlsd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [tlsd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import tlsd_pkg::*;

    logic [15:0] r_max_len;
    logic        r_filter;
    logic [63:0] r_start_seq;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    t_cfg        cfg;

    logic        accept;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_entry      wr_entry;
    t_entry      rd_entry;
    t_entry      out_entry;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RST;
            r_filter    <= 1'b0;
            r_start_seq <= START_SEQ_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MAX_LEN:   r_max_len   <= pwdata[15:0];
                REG_FILTER:    r_filter    <= pwdata[0];
                REG_START_SEQ: r_start_seq <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_MAX_LEN:   prdata = {48'd0, r_max_len};
            REG_FILTER:    prdata = {63'd0, r_filter};
            REG_START_SEQ: prdata = r_start_seq;
            default:       prdata = '0;
        endcase
    end

    assign cfg.max_len   = r_max_len;
    assign cfg.filter    = r_filter;
    assign cfg.seq_load  = cfg_wr && (cfg_idx == REG_START_SEQ);
    assign cfg.seq_value = pwdata;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    tlsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_entry     (wr_entry)
    );

    tlsd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (wr_entry),
        .i_pop     (pop),
        .o_rd_data (rd_entry),
        .o_full    (full),
        .o_empty   (empty)
    );

    tlsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .i_rd_data (rd_entry),
        .o_pop     (pop),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_entry   (out_entry)
    );

    assign o_kind            = out_entry.kind;
    assign o_payload_byte    = out_entry.payload_byte;
    assign o_record_type     = out_entry.record_type;
    assign o_record_length   = out_entry.record_length;
    assign o_record_sequence = out_entry.record_sequence;
    assign o_last            = out_entry.last;
    assign o_error_code      = out_entry.error_code;

endmodule
